### hw/rtl/tspp_pkg.sv
`default_nettype none

package tspp_pkg;

    // Packet length default; the parser accepts 188 up to 208.
    localparam int unsigned PACKET_BYTES_DEF = 188;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 8;   // holds any index below 208
    localparam int unsigned START_W     = 10;
    localparam int unsigned HEADER_W    = 24;  // header bytes 1..3, sync byte dropped
    localparam int unsigned CLOCK_W     = 48;
    localparam int unsigned PID_W       = 13;
    localparam int unsigned BASE_W      = 33;
    localparam int unsigned EXT_W       = 9;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE     = 8'h47;
    localparam logic [START_W-1:0] START_NONE    = 10'd1023;
    localparam logic [START_W-1:0] PAYLOAD_LIMIT = 10'd188;  // header plus 184 payload bytes
    localparam logic [INDEX_W-1:0] HEADER_LAST   = 8'd3;
    localparam logic [INDEX_W-1:0] ADAPT_LEN_IDX = 8'd4;
    localparam logic [INDEX_W-1:0] ADAPT_FLG_IDX = 8'd5;
    localparam logic [INDEX_W-1:0] PCR_FIRST_IDX = 8'd6;
    localparam logic [INDEX_W-1:0] PCR_LAST_IDX  = 8'd11;
    localparam int unsigned        PCR_FLAG_BIT  = 4;

    // adaptation field control codes
    localparam logic [1:0] AFC_PAYLOAD = 2'd1;
    localparam logic [1:0] AFC_ADAPT   = 2'd2;
    localparam logic [1:0] AFC_BOTH    = 2'd3;

    // result queue, depth must be a power of two
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD     = 2'd0,
        KIND_SUMMARY     = 2'd1,
        KIND_SUMMARY_PCR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [PID_W-1:0]   packet_id;
        logic               error_flag;
        logic               unit_start;
        logic               priority_flag;
        logic [1:0]         scramble_bits;
        logic [1:0]         field_control;
        logic [3:0]         continuity;
        logic [BASE_W-1:0]  clock_base;
        logic [EXT_W-1:0]   clock_extension;
        logic               last;
    } result_t;

    // up to two results per byte, first is the payload byte when both exist
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

### hw/rtl/tspp_parse.sv
`default_nettype none

module tspp_parse #(
    parameter int unsigned PACKET_BYTES = tspp_pkg::PACKET_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [tspp_pkg::BYTE_W-1:0]   in_byte,
    output logic                               in_ready,
    input  wire logic                          room,
    output tspp_pkg::push_t                    push
);
    import tspp_pkg::*;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(PACKET_BYTES - 1);

    logic                  in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  advance;

    logic                  in_packet_reg, in_packet_next;
    logic [INDEX_W-1:0]    byte_index_reg, byte_index_next;
    logic [HEADER_W-1:0]   header_reg, header_next;
    logic [BYTE_W-1:0]     adapt_length_reg, adapt_length_next;
    logic                  pcr_flag_reg, pcr_flag_next;
    logic [START_W-1:0]    payload_start_reg, payload_start_next;
    logic [CLOCK_W-1:0]    clock_shift_reg, clock_shift_next;

    logic [1:0]            afc_cur, afc_new;
    logic                  pusi_cur, pusi_new;
    logic [START_W-1:0]    offset;
    logic                  emit_payload, emit_summary, has_pcr;
    result_t               res_pay, res_sum;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || advance;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

    assign afc_cur  = header_reg[5:4];
    assign pusi_cur = header_reg[22];
    assign offset   = START_W'(byte_index_reg) + START_W'(1) + START_W'(in_byte_reg);

    always_comb begin
        in_packet_next     = in_packet_reg;
        byte_index_next    = byte_index_reg;
        header_next        = header_reg;
        adapt_length_next  = adapt_length_reg;
        pcr_flag_next      = pcr_flag_reg;
        payload_start_next = payload_start_reg;
        clock_shift_next   = clock_shift_reg;
        afc_new            = afc_cur;
        pusi_new           = pusi_cur;
        emit_payload       = 1'b0;
        emit_summary       = 1'b0;

        if (!in_packet_reg) begin
            if (in_byte_reg == SYNC_BYTE) begin
                in_packet_next     = 1'b1;
                byte_index_next    = INDEX_W'(1);
                header_next        = HEADER_W'(SYNC_BYTE);
                adapt_length_next  = '0;
                pcr_flag_next      = 1'b0;
                payload_start_next = START_NONE;
                clock_shift_next   = '0;
            end
        end else begin
            if (byte_index_reg <= HEADER_LAST) begin
                header_next = {header_reg[HEADER_W-9:0], in_byte_reg};
                afc_new     = header_next[5:4];
                pusi_new    = header_next[22];
                if (byte_index_reg == HEADER_LAST && afc_new == AFC_PAYLOAD && !pusi_new) begin
                    payload_start_next = START_W'(4);
                end
            end else if (byte_index_reg == ADAPT_LEN_IDX) begin
                if (afc_cur == AFC_PAYLOAD) begin
                    if (pusi_cur) begin
                        payload_start_next = offset;
                    end
                end else if (afc_cur[1]) begin
                    adapt_length_next = in_byte_reg;
                    if (afc_cur == AFC_BOTH && !pusi_cur) begin
                        payload_start_next = offset;
                    end
                end
            end else begin
                if (byte_index_reg == ADAPT_FLG_IDX && afc_cur[1] && adapt_length_reg != '0) begin
                    pcr_flag_next = in_byte_reg[PCR_FLAG_BIT];
                end
                if (byte_index_reg >= PCR_FIRST_IDX && byte_index_reg <= PCR_LAST_IDX) begin
                    clock_shift_next = {clock_shift_reg[CLOCK_W-9:0], in_byte_reg};
                end
                // pointer field right after the adaptation field
                if (afc_cur == AFC_BOTH && pusi_cur
                    && {1'b0, byte_index_reg} == 9'd5 + {1'b0, adapt_length_reg}) begin
                    payload_start_next = offset;
                end
            end

            emit_payload = START_W'(byte_index_reg) >= payload_start_next
                           && START_W'(byte_index_reg) < PAYLOAD_LIMIT;

            if (byte_index_reg >= LAST_INDEX) begin
                emit_summary    = 1'b1;
                in_packet_next  = 1'b0;
                byte_index_next = '0;
            end else begin
                byte_index_next = byte_index_reg + INDEX_W'(1);
            end
        end
    end

    assign has_pcr = afc_new[1] && adapt_length_next != '0 && pcr_flag_next;

    always_comb begin
        res_pay.kind            = KIND_PAYLOAD;
        res_pay.payload_byte    = in_byte_reg;
        res_pay.packet_id       = header_next[20:8];
        res_pay.error_flag      = header_next[23];
        res_pay.unit_start      = header_next[22];
        res_pay.priority_flag   = header_next[21];
        res_pay.scramble_bits   = header_next[7:6];
        res_pay.field_control   = header_next[5:4];
        res_pay.continuity      = header_next[3:0];
        res_pay.clock_base      = '0;
        res_pay.clock_extension = '0;
        res_pay.last            = !emit_summary;

        res_sum                 = res_pay;
        res_sum.kind            = has_pcr ? KIND_SUMMARY_PCR : KIND_SUMMARY;
        res_sum.payload_byte    = '0;
        res_sum.clock_base      = has_pcr ? clock_shift_next[CLOCK_W-1:15] : '0;
        res_sum.clock_extension = has_pcr ? clock_shift_next[EXT_W-1:0] : '0;
        res_sum.last            = 1'b1;

        push.first  = emit_payload ? res_pay : res_sum;
        push.second = res_sum;
        push.count  = advance ? (2'(emit_payload) + 2'(emit_summary)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg     <= 1'b0;
            byte_index_reg    <= '0;
            header_reg        <= '0;
            adapt_length_reg  <= '0;
            pcr_flag_reg      <= 1'b0;
            payload_start_reg <= '0;
            clock_shift_reg   <= '0;
        end else if (advance) begin
            in_packet_reg     <= in_packet_next;
            byte_index_reg    <= byte_index_next;
            header_reg        <= header_next;
            adapt_length_reg  <= adapt_length_next;
            pcr_flag_reg      <= pcr_flag_next;
            payload_start_reg <= payload_start_next;
            clock_shift_reg   <= clock_shift_next;
        end
    end

    // two results only on the packet's last byte, and then the second is a summary
    a_pair_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> (push.first.kind == KIND_PAYLOAD
                                && push.second.kind != KIND_PAYLOAD
                                && byte_index_reg >= LAST_INDEX))
        else $error("double push outside the last byte");

    // leaving a packet always comes with a summary
    a_exit_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(in_packet_reg) |-> $past(emit_summary && advance))
        else $error("packet closed without summary");

endmodule

`default_nettype wire

### hw/rtl/tspp_queue.sv
`default_nettype none

module tspp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tspp_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tspp_pkg::result_t      out_item
);
    import tspp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_2nd;
    logic               pop;

    // room for two more regardless of the read side this cycle
    assign room      = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_2nd  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (push.count != 2'd0 && wr_ptr_reg == PTR_W'(k)) begin
                entry_reg[k] <= push.first;
            end else if (push.count == 2'd2 && wr_ptr_2nd == PTR_W'(k)) begin
                entry_reg[k] <= push.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> room)
        else $error("result queue written without room");

    a_count_tracks_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH)
        && PTR_W'(count_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

### hw/rtl/ts_packet_parser.sv
`default_nettype none

// Channel   Dir  Ports                         Carries
// s_        in   s_tvalid s_tready s_tdata     one raw transport stream byte
// m_        out  m_tvalid m_tready m_tdata     payload bytes and packet summaries,
//                m_tuser m_tlast                kind in tuser, tlast on a byte's final result
//
// Sustains one input byte per cycle while the result queue has room. Each
// byte passes an input register, the parser logic and a four-entry result
// queue. The packet's last byte can give two results (payload byte
// and summary); the queue takes both at once and drains during the following
// header bytes. aresetn (synchronous) returns the parser to hunting for sync.
// Input is held off only while the queue holds more than two results.

module ts_packet_parser #(
    parameter int unsigned PACKET_BYTES = tspp_pkg::PACKET_BYTES_DEF   // 188 to 208
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] stream_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,    // [7:0] payload_byte, [20:8] packet_id,
                                         // [21] error_flag, [22] unit_start,
                                         // [23] priority_flag, [25:24] scramble_bits,
                                         // [27:26] field_control, [31:28] continuity,
                                         // [64:32] clock_base, [73:65] clock_extension,
                                         // [79:74] zero
    output logic [1:0]       m_tuser,    // [1:0] kind
    output logic             m_tlast     // last
);
    import tspp_pkg::*;

    push_t    push;
    logic     room;
    result_t  item;

    // byte register, header/adaptation capture and offset tracking
    tspp_parse #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .room     (room),
        .push     (push)
    );

    // result queue decouples the two sides and absorbs the summary
    tspp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {6'b0,
                      item.clock_extension,
                      item.clock_base,
                      item.continuity,
                      item.field_control,
                      item.scramble_bits,
                      item.priority_flag,
                      item.unit_start,
                      item.error_flag,
                      item.packet_id,
                      item.payload_byte};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;

    // payload bytes never carry a PCR
    a_payload_no_pcr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[73:32] == '0)
        else $error("payload result with clock fields set");

endmodule

`default_nettype wire

### bench/tb_ts_packet_parser.sv
`timescale 1ns / 1ps

module tb_ts_packet_parser;

    import tspp_pkg::*;

    localparam int unsigned PKT_LEN      = PACKET_BYTES_DEF;
    localparam int unsigned HEADER_LEN   = 4;
    localparam int unsigned PAYLOAD_LEN  = 184;
    localparam int unsigned LONG_HOLD    = 300;   // cycles of receiver hold-off
    localparam int unsigned LATENCY_PAD  = 16;    // margin on top of the parser latency
    localparam int unsigned DRAIN_LIMIT  = 4000;
    localparam int unsigned REPORT_LIMIT = 10;

    // adaptation field control value that carries nothing
    localparam logic [1:0]  AFC_INVALID  = 2'd0;

    // idle patterns on the two channels
    typedef enum logic [1:0] {
        GAP_NONE     = 2'd0,
        GAP_SENDER   = 2'd1,
        GAP_RECEIVER = 2'd2,
        GAP_BOTH     = 2'd3
    } gap_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    ts_packet_parser #(
        .PACKET_BYTES (PKT_LEN)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shared state between stimulus, driver and monitor
    // ------------------------------------------------------------------
    logic [7:0] stream_bytes [$];   // bytes waiting to be offered, head is on the bus
    result_t    due_results  [$];   // parser output still to arrive, oldest first

    gap_mode_t  gap_mode = GAP_NONE;
    int         sender_idle_pct;
    int         receiver_stall_pct;

    logic       hold_start  = 1'b0; // raised by stimulus, taken once by the hold process
    logic       hold_used   = 1'b0;
    logic       hold_active = 1'b0;
    int         hold_left   = 0;

    int         mismatches      = 0;
    int         leftover        = 0;
    int         results_checked = 0;
    int         bytes_accepted  = 0;
    int         packets_queued  = 0;
    int         packets_parsed  = 0;
    int         payload_due     = 0;
    int         pcr_due         = 0;

    result_t    seen;
    result_t    want;

    always_comb begin
        sender_idle_pct    = (gap_mode == GAP_SENDER)   ? 45 :
                             (gap_mode == GAP_BOTH)     ? 10 : 0;
        receiver_stall_pct = (gap_mode == GAP_RECEIVER) ? 45 :
                             (gap_mode == GAP_BOTH)     ? 10 : 0;
    end

    // ------------------------------------------------------------------
    // Packet parser model: own copy of the per-packet state
    // ------------------------------------------------------------------
    logic        pk_open       = 1'b0;   // low while hunting for sync
    int unsigned pk_index      = 0;
    logic [31:0] pk_header     = '0;
    int unsigned pk_adapt_len  = 0;
    logic [7:0]  pk_adapt_flgs = '0;
    int unsigned pk_payload_at = 0;      // START_NONE while unknown or absent
    logic [47:0] pk_clock      = '0;

    // header fields of the packet in progress, PCR only when asked for
    function automatic result_t make_result(kind_t k, logic [7:0] pb, logic with_clock);
        result_t r;
        r.kind            = k;
        r.payload_byte    = pb;
        r.packet_id       = pk_header[20:8];
        r.error_flag      = pk_header[23];
        r.unit_start      = pk_header[22];
        r.priority_flag   = pk_header[21];
        r.scramble_bits   = pk_header[7:6];
        r.field_control   = pk_header[5:4];
        r.continuity      = pk_header[3:0];
        r.clock_base      = with_clock ? pk_clock[47:15] : '0;
        r.clock_extension = with_clock ? pk_clock[8:0]   : '0;
        r.last            = 1'b0;
        return r;
    endfunction

    // Advances the model by one accepted stream byte and queues what it causes.
    task automatic parse_stream_byte(input logic [7:0] b);
        int unsigned i;
        logic [1:0]  afc;
        logic        pusi;
        logic        is_payload;
        logic        ends;
        logic        with_pcr;
        result_t     payload_res;
        result_t     summary_res;
        if (!pk_open) begin
            if (b == SYNC_BYTE) begin
                pk_open       = 1'b1;
                pk_index      = 1;
                pk_header     = 32'(SYNC_BYTE);
                pk_adapt_len  = 0;
                pk_adapt_flgs = '0;
                pk_payload_at = START_NONE;
                pk_clock      = '0;
            end
            return;
        end

        i = pk_index;
        if (i < HEADER_LEN) begin
            pk_header = {pk_header[23:0], b};
            // plain payload packet: offset known once the header is in
            if (i == HEADER_LEN - 1 && pk_header[5:4] == AFC_PAYLOAD && !pk_header[22]) begin
                pk_payload_at = HEADER_LEN;
            end
        end else begin
            afc  = pk_header[5:4];
            pusi = pk_header[22];
            if (i == HEADER_LEN) begin
                if (afc == AFC_PAYLOAD) begin
                    if (pusi) begin
                        pk_payload_at = (i + 1 + b) & 'h3FF;   // pointer field
                    end
                end else if (afc == AFC_BOTH) begin
                    pk_adapt_len = b;
                    if (!pusi) begin
                        pk_payload_at = (i + 1 + b) & 'h3FF;
                    end
                end else if (afc == AFC_ADAPT) begin
                    pk_adapt_len = b;
                end
            end else begin
                // flags only count when the adaptation field is not empty
                if (i == 5 && afc[1] && pk_adapt_len != 0) begin
                    pk_adapt_flgs = b;
                end
                if (i >= 6 && i <= 11) begin
                    pk_clock = {pk_clock[39:0], b};
                end
                // pointer field sits just after the adaptation field
                if (afc == AFC_BOTH && pusi && i == 5 + pk_adapt_len) begin
                    pk_payload_at = (i + 1 + b) & 'h3FF;
                end
            end
        end

        is_payload = (i >= pk_payload_at) && (i < HEADER_LEN + PAYLOAD_LEN);
        ends       = (i + 1 >= PKT_LEN);

        if (is_payload) begin
            payload_res      = make_result(KIND_PAYLOAD, b, 1'b0);
            payload_res.last = !ends;
            due_results.insert(due_results.size(), payload_res);
            payload_due++;
        end

        if (ends) begin
            afc      = pk_header[5:4];
            with_pcr = afc[1] && pk_adapt_len != 0 && pk_adapt_flgs[PCR_FLAG_BIT];
            summary_res      = make_result(with_pcr ? KIND_SUMMARY_PCR : KIND_SUMMARY,
                                           8'h00, with_pcr);
            summary_res.last = 1'b1;
            due_results.insert(due_results.size(), summary_res);
            packets_parsed++;
            if (with_pcr) begin
                pcr_due++;
            end
            pk_open  = 1'b0;
            pk_index = 0;
        end else begin
            pk_index = i + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the head of stream_bytes, holds it until the request
    // is taken, then feeds the byte to the model.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_stream_byte(s_tdata);
                void'(stream_bytes.pop_front());
                bytes_accepted++;
            end
            // a pending request stays on the bus unchanged
            if (!s_tvalid || s_tready) begin
                if (stream_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_bytes[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here so the queue fills and the
    // parser has to hold back its input.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_active <= 1'b0;
            hold_used   <= 1'b0;
            hold_left   <= 0;
        end else if (hold_start && !hold_used) begin
            hold_active <= 1'b1;
            hold_used   <= 1'b1;
            hold_left   <= LONG_HOLD;
        end else if (hold_active) begin
            if (hold_left == 1) begin
                hold_active <= 1'b0;
            end
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result request is checked against the oldest
    // expectation, all fields at once; details for the first few.
    // ------------------------------------------------------------------
    function automatic string describe(result_t r);
        return $sformatf({"kind=%0d byte=%02h pid=%04h tei=%0b pusi=%0b prio=%0b scr=%0d ",
                          "afc=%0d cc=%0d base=%09h ext=%03h last=%0b"},
                         r.kind, r.payload_byte, r.packet_id, r.error_flag, r.unit_start,
                         r.priority_flag, r.scramble_bits, r.field_control, r.continuity,
                         r.clock_base, r.clock_extension, r.last);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.kind            = kind_t'(m_tuser);
                seen.payload_byte    = m_tdata[7:0];
                seen.packet_id       = m_tdata[20:8];
                seen.error_flag      = m_tdata[21];
                seen.unit_start      = m_tdata[22];
                seen.priority_flag   = m_tdata[23];
                seen.scramble_bits   = m_tdata[25:24];
                seen.field_control   = m_tdata[27:26];
                seen.continuity      = m_tdata[31:28];
                seen.clock_base      = m_tdata[64:32];
                seen.clock_extension = m_tdata[73:65];
                seen.last            = m_tlast;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result: %s", $realtime, describe(seen));
                    end
                end else begin
                    want = due_results.pop_front();
                    results_checked++;
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d mismatch\n  expected %s\n  actual   %s",
                                     $realtime, results_checked, describe(want),
                                     describe(seen));
                        end
                    end
                end
            end
            if (hold_active) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [23:0] ts_header(logic tei, logic pusi, logic prio,
                                              logic [12:0] pid, logic [1:0] scr,
                                              logic [1:0] afc, logic [3:0] cc);
        return {tei, pusi, prio, pid, scr, afc, cc};
    endfunction

    // Whole packet: sync, header, bytes 4 and 5, PCR bytes 6..11, an optional
    // pointer byte placed last, the rest random or a fixed fill.
    task automatic queue_packet(input logic [23:0] hdr, input logic [7:0] byte4,
                                input logic [7:0] byte5, input logic [47:0] pcr,
                                input int ptr_at, input logic [7:0] ptr_val,
                                input int fill);
        logic [7:0] pkt [PKT_LEN];
        int         k;
        for (k = 0; k < PKT_LEN; k++) begin
            pkt[k] = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
        end
        pkt[0] = SYNC_BYTE;
        pkt[1] = hdr[23:16];
        pkt[2] = hdr[15:8];
        pkt[3] = hdr[7:0];
        pkt[4] = byte4;
        pkt[5] = byte5;
        for (k = 0; k < 6; k++) begin
            pkt[6 + k] = pcr[47 - 8 * k -: 8];
        end
        if (ptr_at >= 0 && ptr_at < PKT_LEN) begin
            pkt[ptr_at] = ptr_val;
        end
        for (k = 0; k < PKT_LEN; k++) begin
            stream_bytes.insert(stream_bytes.size(), pkt[k]);
        end
        packets_queued++;
    endtask

    // Bytes seen while hunting; a stray sync here breaks the alignment.
    task automatic queue_noise(input int count, input logic allow_sync);
        logic [7:0] nb;
        repeat (count) begin
            nb = 8'($urandom_range(255));
            while (nb == SYNC_BYTE && !allow_sync) begin
                nb = 8'($urandom_range(255));
            end
            stream_bytes.insert(stream_bytes.size(), nb);
        end
    endtask

    // Lets the sender run dry, then moves to the next idle pattern.
    task automatic advance_gaps();
        while (stream_bytes.size() != 0) begin
            @(negedge aclk);
        end
        gap_mode = gap_mode_t'(gap_mode + 1);
    endtask

    // Sender pause: nothing offered until every expected result is in.
    task automatic pause_until_drained();
        while (stream_bytes.size() != 0 || due_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (LATENCY_PAD) @(negedge aclk);
    endtask

    initial begin
        int guard;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- no idling: hunting bytes, then adaptation plus payload with unit
        //     start, header fields and PCR at all ones, pointer after the field
        stream_bytes.insert(stream_bytes.size(), 8'h00);
        stream_bytes.insert(stream_bytes.size(), 8'hFF);
        stream_bytes.insert(stream_bytes.size(), 8'h46);
        stream_bytes.insert(stream_bytes.size(), 8'h48);
        stream_bytes.insert(stream_bytes.size(), 8'hB8);
        queue_packet(ts_header(1, 1, 1, 13'h1FFF, 2'd3, AFC_BOTH, 4'hF),
                     8'd10, 8'hFF, 48'hFFFF_FFFF_FFFF, 15, 8'd3, -1);
        advance_gaps();

        // --- sender idling: pointer leaves only the last byte as payload, so it
        //     pairs with the summary; sync values used as ordinary data
        queue_packet(ts_header(0, 1, 0, 13'h0000, 2'd0, AFC_PAYLOAD, 4'h0),
                     8'd182, SYNC_BYTE, {6{SYNC_BYTE}}, -1, 8'h00, SYNC_BYTE);
        queue_noise(3, 1'b0);
        advance_gaps();

        // --- receiver stalling: invalid control value, summary only
        queue_packet(ts_header(0, 0, 1, 13'h0ABC, 2'd2, AFC_INVALID, 4'h3),
                     8'd20, 8'h10, 48'hFFFF_FFFF_FFFF, -1, 8'h00, -1);
        advance_gaps();
        pause_until_drained();

        // --- both idling, receiver held off for a long stretch while the
        //     sender keeps offering a plain payload packet
        hold_start = 1'b1;
        queue_packet(ts_header(1, 0, 0, 13'h1555, 2'd1, AFC_PAYLOAD, 4'h7),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     {16'h5A5A, 32'($urandom)}, -1, 8'h00, -1);

        // --- wind down
        while (stream_bytes.size() != 0) begin
            @(negedge aclk);
        end
        gap_mode = GAP_NONE;
        guard    = 0;
        while (due_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        repeat (LATENCY_PAD) @(negedge aclk);
        leftover = due_results.size();
        if (leftover != 0) begin
            $display("%0d expected results never arrived", leftover);
        end

        $display("Covered %0d stream bytes in %0d queued packets (%0d parsed) over four idle",
                 bytes_accepted, packets_queued, packets_parsed);
        $display("patterns and a long receiver hold; %0d results checked, %0d payload, %0d PCR",
                 results_checked, payload_due, pcr_due);
        if (mismatches == 0 && leftover == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
